// ===== rtl/nnpo_pkg.sv =====
package nnpo_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned MODE_W  = 3;

  // start point selection
  localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BOTTOM = 3'd4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_z;
    logic                      last_point;
  } nnpo_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      last_out;
    logic                      overflowed;
  } nnpo_out_t;

  typedef struct packed {
    logic              wr_point;
    logic              scan_clr;
    logic              scan_issue;
    logic              scan_nn;
    logic [MODE_W-1:0] mode;
    logic              fetch;
    logic              emit;
    logic              emit_last;
    logic              emit_ovf;
  } nnpo_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic have_best;
  } nnpo_sts_t;

endpackage

// ===== rtl/nnpo_dp.sv =====
module nnpo_dp
  import nnpo_pkg::*;
#(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nnpo_cmd_t                     cmd,
  input  nnpo_in_t                      in_point,
  input  logic [$clog2(MAX_POINTS)-1:0] wr_idx,
  input  logic [$clog2(MAX_POINTS)-1:0] scan_idx,
  output nnpo_sts_t                     sts,
  output logic                          out_valid,
  output nnpo_out_t                     out_data
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = COORD_WIDTH;
  localparam int HL = (CW + 1) / 2;
  localparam int HH = CW - HL;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 1;

  logic [3*CW-1:0] point_mem [MAX_POINTS];
  logic            taken_mem [MAX_POINTS];

  logic [3*CW-1:0] rd_q_r;
  logic            tk_q_r;
  logic [IW-1:0]   rd_addr;

  logic signed [CW-1:0] rd_x, rd_y, rd_z;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [CW-1:0] bx_r, by_r;

  logic          s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [IW-1:0] s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  logic          s2_tk_r, s3_tk_r, s4_tk_r, s5_tk_r;

  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      ax_r, ay_r;
  logic [2*HL-1:0]    xll_r, yll_r;
  logic [HL+HH-1:0]   xlh_r, ylh_r;
  logic [2*HH-1:0]    xhh_r, yhh_r;
  logic [PW-1:0]      sqx_r, sqy_r;
  logic [SW-1:0]      dist_r, best_dist_r;

  logic          have_r;
  logic [IW-1:0] best_idx_r;
  logic          pick_better;
  logic          out_valid_r;
  nnpo_out_t     out_r;

  assign rd_addr = cmd.fetch ? best_idx_r : scan_idx;
  assign rd_x = rd_q_r[CW-1:0];
  assign rd_y = rd_q_r[2*CW-1:CW];
  assign rd_z = rd_q_r[3*CW-1:2*CW];

  // point and taken memories
  always_ff @(posedge clk) begin
    if (cmd.wr_point) begin
      point_mem[wr_idx] <= {CW'($signed(in_point.point_z)),
                            CW'($signed(in_point.point_y)),
                            CW'($signed(in_point.point_x))};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_point) begin
      taken_mem[wr_idx] <= 1'b0;
    end else if (cmd.emit) begin
      taken_mem[best_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= point_mem[rd_addr];
    tk_q_r <= taken_mem[rd_addr];
  end

  // start point pick works straight off the read data
  always_comb begin
    case (cmd.mode)
      MODE_TOP:    pick_better = rd_y > by_r;
      MODE_LEFT:   pick_better = rd_x < bx_r;
      MODE_RIGHT:  pick_better = rd_x > bx_r;
      MODE_BOTTOM: pick_better = rd_y < by_r;
      default:     pick_better = 1'b0;
    endcase
  end

  assign dx = $signed({rd_x[CW-1], rd_x}) - $signed({cx_r[CW-1], cx_r});
  assign dy = $signed({rd_y[CW-1], rd_y}) - $signed({cy_r[CW-1], cy_r});

  // distance pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.scan_issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= scan_idx;
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    s4_idx_r <= s3_idx_r;
    s5_idx_r <= s4_idx_r;
    s2_tk_r  <= tk_q_r;
    s3_tk_r  <= s2_tk_r;
    s4_tk_r  <= s3_tk_r;
    s5_tk_r  <= s4_tk_r;
    // |a - b| of two CW-bit values always fits in CW bits
    ax_r <= dx[CW] ? CW'(-dx) : CW'(dx);
    ay_r <= dy[CW] ? CW'(-dy) : CW'(dy);
    xll_r <= (2*HL)'(ax_r[HL-1:0]) * (2*HL)'(ax_r[HL-1:0]);
    xlh_r <= (HL+HH)'(ax_r[HL-1:0]) * (HL+HH)'(ax_r[CW-1:HL]);
    xhh_r <= (2*HH)'(ax_r[CW-1:HL]) * (2*HH)'(ax_r[CW-1:HL]);
    yll_r <= (2*HL)'(ay_r[HL-1:0]) * (2*HL)'(ay_r[HL-1:0]);
    ylh_r <= (HL+HH)'(ay_r[HL-1:0]) * (HL+HH)'(ay_r[CW-1:HL]);
    yhh_r <= (2*HH)'(ay_r[CW-1:HL]) * (2*HH)'(ay_r[CW-1:HL]);
    sqx_r <= PW'(xll_r) + (PW'(xlh_r) << (HL + 1)) + (PW'(xhh_r) << (2 * HL));
    sqy_r <= PW'(yll_r) + (PW'(ylh_r) << (HL + 1)) + (PW'(yhh_r) << (2 * HL));
    dist_r <= SW'(sqx_r) + SW'(sqy_r);
  end

  // best candidate tracking; strict compare keeps the earliest on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r     <= 1'b0;
      best_idx_r <= '0;
    end else if (cmd.scan_clr) begin
      have_r     <= 1'b0;
      best_idx_r <= '0;
    end else if (!cmd.scan_nn) begin
      if (s1_vld_r && (!have_r || pick_better)) begin
        have_r     <= 1'b1;
        best_idx_r <= s1_idx_r;
      end
    end else if (s5_vld_r && !s5_tk_r && (!have_r || dist_r < best_dist_r)) begin
      have_r     <= 1'b1;
      best_idx_r <= s5_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.scan_nn && s1_vld_r && (!have_r || pick_better)) begin
      bx_r <= rd_x;
      by_r <= rd_y;
    end
    if (cmd.scan_nn && s5_vld_r && !s5_tk_r && (!have_r || dist_r < best_dist_r)) begin
      best_dist_r <= dist_r;
    end
    if (cmd.emit) begin
      cx_r <= rd_x;
      cy_r <= rd_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_x      <= FIELD_W'(rd_x);
      out_r.out_y      <= FIELD_W'(rd_y);
      out_r.out_z      <= FIELD_W'(rd_z);
      out_r.last_out   <= cmd.emit_last;
      out_r.overflowed <= cmd.emit_ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.pipe_busy = s1_vld_r | s2_vld_r | s3_vld_r | s4_vld_r | s5_vld_r;
  assign sts.have_best = have_r;

  // a fetch always sits between two beats
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

  // a nearest-neighbor scan that drained must have found a free point
  a_nn_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fetch && cmd.scan_nn) |-> have_r)
    else $error("fetch without a candidate");

endmodule

// ===== rtl/nnpo_ctrl.sv =====
module nnpo_ctrl
  import nnpo_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          last_in,
  output logic                          busy,
  input  logic                          cfg_valid,
  input  logic [MODE_W-1:0]             cfg_data,
  output logic                          cfg_ready,
  output nnpo_cmd_t                     cmd,
  output logic [$clog2(MAX_POINTS)-1:0] wr_idx,
  output logic [$clog2(MAX_POINTS)-1:0] scan_idx,
  input  nnpo_sts_t                     sts
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = IW + 1;
  localparam logic [NW-1:0] NMAX = NW'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [NW-1:0]     count_r;
  logic [NW-1:0]     emit_cnt_r;
  logic [IW-1:0]     j_r;
  logic              drop_r;
  logic              nn_r;
  logic [MODE_W-1:0] mode_r;

  logic          accept;
  logic          room;
  logic [NW-1:0] n_nxt;
  logic          mode_scan;
  logic          emit_last;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign room      = count_r < NMAX;
  assign n_nxt     = room ? count_r + NW'(1) : count_r;
  assign emit_last = (emit_cnt_r + NW'(1)) == count_r;

  always_comb begin
    mode_scan = mode_r inside {MODE_TOP, MODE_LEFT, MODE_RIGHT, MODE_BOTTOM};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      emit_cnt_r <= '0;
      j_r        <= '0;
      drop_r     <= 1'b0;
      nn_r       <= 1'b0;
      mode_r     <= MODE_FIRST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r <= n_nxt;
            if (!room) begin
              drop_r <= 1'b1;
            end
            if (last_in) begin
              nn_r <= 1'b0;
              j_r  <= '0;
              if (n_nxt > NW'(1) && mode_scan) begin
                state_r <= S_SCAN;
              end else begin
                state_r <= S_FETCH;
              end
            end
          end
        end
        S_SCAN: begin
          j_r <= j_r + IW'(1);
          if ({1'b0, j_r} == count_r - NW'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!sts.pipe_busy) begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_last) begin
            state_r    <= S_IDLE;
            count_r    <= '0;
            emit_cnt_r <= '0;
            drop_r     <= 1'b0;
          end else begin
            emit_cnt_r <= emit_cnt_r + NW'(1);
            nn_r       <= 1'b1;
            j_r        <= '0;
            state_r    <= S_SCAN;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.wr_point   = accept && room;
    cmd.scan_clr   = (state_r == S_IDLE) || (state_r == S_EMIT);
    cmd.scan_issue = (state_r == S_SCAN);
    cmd.scan_nn    = nn_r;
    cmd.mode       = mode_r;
    cmd.fetch      = (state_r == S_FETCH);
    cmd.emit       = (state_r == S_EMIT);
    cmd.emit_last  = emit_last;
    cmd.emit_ovf   = drop_r;
  end

  assign wr_idx   = count_r[IW-1:0];
  assign scan_idx = j_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (emit_cnt_r < count_r && count_r <= NMAX))
    else $error("emit index out of range");

  a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_in) |=> busy)
    else $error("last point did not start ordering");

  a_run_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_last) |=> (state_r == S_IDLE && count_r == '0 && !drop_r))
    else $error("set not cleared after final beat");

  a_fetch_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && $past(state_r) == S_DRAIN) |-> sts.have_best)
    else $error("scan drained without a best point");

endmodule

// ===== rtl/nearest_neighbor_point_ordering.sv =====
// channel | ports                              | handshake
// --------+------------------------------------+-----------------------------------
// input   | start, busy, in_point              | beat when start && !busy
// result  | out_valid, out_data                | one-cycle strobe, no backpressure
// config  | cfg_valid, cfg_ready, cfg_data     | write when cfg_valid && cfg_ready
//
// Loading takes one point per cycle while busy is low. The item with last_point starts
// ordering of n points. A start pick (modes 1..4, n >= 2) first reads all n points. Each beat
// is then found by n reads through the single read port of the point memory into a 5-stage
// distance pipeline, a drain, then the fetch and emit states. Reset is synchronous; no memory
// clearing pass. The receiver cannot stall, so every beat leaves on its strobe; busy stays
// high from the last point and falls as the final beat goes out.
module nearest_neighbor_point_ordering
  import nnpo_pkg::*;
#(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  nnpo_in_t          in_point,
  output logic              out_valid,
  output nnpo_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_POINTS);

  nnpo_cmd_t     cmd;
  nnpo_sts_t     sts;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] scan_idx;

  nnpo_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_in   (in_point.last_point),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .wr_idx    (wr_idx),
    .scan_idx  (scan_idx),
    .sts       (sts)
  );

  nnpo_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_point  (in_point),
    .wr_idx    (wr_idx),
    .scan_idx  (scan_idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sim/nearest_neighbor_point_ordering_tb.sv =====
`timescale 1ns / 1ps

module nearest_neighbor_point_ordering_tb;
  import nnpo_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE      = 24;

  // codes past the last defined mode; the block treats them as first-loaded
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  nnpo_in_t          in_point;
  logic              out_valid;
  nnpo_out_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_data;

  nearest_neighbor_point_ordering #(
    .MAX_POINTS (CAPACITY),
    .COORD_WIDTH(FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_point (in_point),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the point store and the mode register
  logic signed [FIELD_W-1:0] held_x [CAPACITY];
  logic signed [FIELD_W-1:0] held_y [CAPACITY];
  logic signed [FIELD_W-1:0] held_z [CAPACITY];
  int                        held_n;
  bit                        held_drop;
  logic [MODE_W-1:0]         sel_mode;

  nnpo_out_t tour_queue [$];
  int        mismatch_count;
  int        burst_left;
  int        cycle_count;

  function automatic int pick_origin();
    int best;
    best = 0;
    for (int i = 1; i < held_n; i++) begin
      case (sel_mode)
        MODE_TOP:    if (held_y[i] > held_y[best]) best = i;
        MODE_LEFT:   if (held_x[i] < held_x[best]) best = i;
        MODE_RIGHT:  if (held_x[i] > held_x[best]) best = i;
        MODE_BOTTOM: if (held_y[i] < held_y[best]) best = i;
        default:     ;
      endcase
    end
    return best;
  endfunction

  // squared x,y distance, exact: each delta fits 33 bits, the sum 66 bits
  function automatic logic [65:0] span2(int a, int b);
    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay;
    dx = {held_x[a][FIELD_W-1], held_x[a]} - {held_x[b][FIELD_W-1], held_x[b]};
    dy = {held_y[a][FIELD_W-1], held_y[a]} - {held_y[b][FIELD_W-1], held_y[b]};
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    return 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
  endfunction

  // store one accepted point; on the set's last point queue the whole tour
  function automatic void ingest_point(nnpo_in_t p);
    bit          taken [CAPACITY];
    int          cur, n, best;
    bit          have;
    logic [65:0] best_d, d;
    nnpo_out_t   r;
    if (held_n < CAPACITY) begin
      held_x[held_n] = p.point_x;
      held_y[held_n] = p.point_y;
      held_z[held_n] = p.point_z;
      held_n++;
    end else begin
      held_drop = 1'b1;
    end
    if (!p.last_point) return;
    n = held_n;
    foreach (taken[i]) taken[i] = 1'b0;
    cur = (n < 2) ? 0 : pick_origin();
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        have   = 1'b0;
        best_d = '0;
        best   = 0;
        for (int j = 0; j < n; j++) begin
          if (!taken[j]) begin
            d = span2(cur, j);
            // strict compare keeps the earliest loaded point on ties
            if (!have || d < best_d) begin
              best_d = d;
              best   = j;
              have   = 1'b1;
            end
          end
        end
        cur = best;
      end
      taken[cur]   = 1'b1;
      r.out_x      = held_x[cur];
      r.out_y      = held_y[cur];
      r.out_z      = held_z[cur];
      r.last_out   = (k == n - 1);
      r.overflowed = held_drop;
      tour_queue.push_back(r);
    end
    held_n    = 0;
    held_drop = 1'b0;
  endfunction

  function automatic void log_mismatch(string what, logic [FIELD_W-1:0] want,
                                       logic [FIELD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  always @(posedge clk) begin : tour_check
    nnpo_out_t want;
    if (rst_n && out_valid) begin
      if (tour_queue.size() == 0) begin
        log_mismatch("unexpected beat, out_x", 'x, out_data.out_x);
      end else begin
        want = tour_queue.pop_front();
        if (out_data.out_x !== want.out_x) log_mismatch("out_x", want.out_x, out_data.out_x);
        if (out_data.out_y !== want.out_y) log_mismatch("out_y", want.out_y, out_data.out_y);
        if (out_data.out_z !== want.out_z) log_mismatch("out_z", want.out_z, out_data.out_z);
        if (out_data.last_out !== want.last_out)
          log_mismatch("last_out", FIELD_W'(want.last_out), FIELD_W'(out_data.last_out));
        if (out_data.overflowed !== want.overflowed)
          log_mismatch("overflowed", FIELD_W'(want.overflowed),
                       FIELD_W'(out_data.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic nnpo_in_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic last);
    nnpo_in_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.last_point = last;
    return p;
  endfunction

  // tight: a few neighboring values, so distance and extreme ties are common
  function automatic logic [31:0] rand_coord(bit tight);
    int v;
    if (tight) begin
      v = $urandom_range(0, 4);
      return v - 2;
    end
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: begin
        v = $urandom_range(0, 64);
        return (v - 32) <<< 16;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(input nnpo_in_t p);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 8);
    end
    in_point <= p;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    ingest_point(p);
  endtask

  task automatic send_cloud(int n, bit tight);
    for (int i = 0; i < n; i++)
      send_point(make_point(rand_coord(tight), rand_coord(tight), rand_coord(1'b0),
                            i == n - 1));
  endtask

  task automatic drain_tours();
    start <= 1'b0;
    while (tour_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start_mode(logic [MODE_W-1:0] m);
    drain_tours();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sel_mode = m;
  endtask

  // mode stays at its reset value: first loaded point leads
  task automatic test_small_sets();
    send_point(make_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
    // farthest possible pair
    send_point(make_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
    send_point(make_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1));
    // three points equally near the first; earliest must follow
    send_point(make_point(32'd0, 32'd0, 32'h0000_0001, 1'b0));
    send_point(make_point(32'd1, 32'd0, 32'h0000_0002, 1'b0));
    send_point(make_point(-32'sd1, 32'd0, 32'h0000_0003, 1'b0));
    send_point(make_point(32'd0, 32'd1, 32'h0000_0004, 1'b1));
  endtask

  task automatic test_start_modes();
    logic [MODE_W-1:0] seq [7] = '{MODE_TOP, MODE_LEFT, MODE_RIGHT, MODE_BOTTOM,
                                   MODE_SPARE_LO, MODE_SPARE_HI, MODE_FIRST};
    foreach (seq[i]) begin
      write_start_mode(seq[i]);
      send_cloud(3, 1'b1);
    end
  endtask

  // full store, then a set whose two extra points are dropped (the last one
  // carries last_point and still triggers ordering)
  task automatic test_capacity();
    write_start_mode(MODE_LEFT);
    send_cloud(CAPACITY, 1'b0);
    write_start_mode(MODE_TOP);
    send_cloud(CAPACITY + 2, 1'b0);
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < 112) begin
      if ($urandom_range(0, 3) == 0)
        write_start_mode(MODE_W'($urandom_range(0, 7)));
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      send_cloud(n, $urandom_range(0, 2) == 0);
      sent += n;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_point       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = MODE_FIRST;
    sel_mode       = MODE_FIRST;
    held_n         = 0;
    held_drop      = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_small_sets();
    test_start_modes();
    test_capacity();
    test_random_sets();

    drain_tours();
    if (mismatch_count == 0 && tour_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nnpo_pkg.sv
rtl/nnpo_dp.sv
rtl/nnpo_ctrl.sv
rtl/nearest_neighbor_point_ordering.sv
sim/nearest_neighbor_point_ordering_tb.sv
